### hw/rtl/mfpc_pkg.sv
package mfpc_pkg;

    localparam int VAL_W    = 10;
    localparam int ANG_W    = 16;
    localparam int SPD_W    = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    // |pos * span| fits 26 bits, |err| * 154 fits 18 bits
    localparam int PROD_A_W = 26;
    localparam int PROD_S_W = 18;

    localparam logic [SPD_W-1:0] SPD_LOW  = 8'd42;
    localparam logic [SPD_W-1:0] SPD_HIGH = 8'd196;
    localparam logic [SPD_W-1:0] SPD_SPAN = 8'd154;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MAX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_THR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_PRES   = 3'd5;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_FWD  = 2'd1,
        CMD_BACK = 2'd2,
        CMD_STOP = 2'd3
    } cmd_t;

endpackage

### hw/rtl/mfpc_sdiv.sv
module mfpc_sdiv #(
    parameter int NUM_W = 26
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_W-1:0]           dividend,
    input  logic [mfpc_pkg::VAL_W-1:0] divisor,
    output logic                       busy,
    output logic [NUM_W-1:0]           quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                       busy_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [mfpc_pkg::VAL_W-1:0] rem_reg;
    logic [mfpc_pkg::VAL_W-1:0] rem_next;
    logic [mfpc_pkg::VAL_W-1:0] div_reg;
    logic [NUM_W-1:0]           quo_reg;
    logic [NUM_W-1:0]           quo_next;
    logic [mfpc_pkg::VAL_W:0]   trial;
    logic [mfpc_pkg::VAL_W:0]   diff;
    logic                       fits;

    // restoring step: dividend bits shift out the top, quotient bits shift in below
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[mfpc_pkg::VAL_W-1:0] : trial[mfpc_pkg::VAL_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/motorized_fader_position_control_unit.sv
// Motorized fader position controller. A request with operation 0 arms a move toward
// target_value; a request with operation 1 brings a converter sample, updates the
// denoised position and, while a move is active, issues a drive command and speed.
// Every request returns one result with the position mapped onto the angle range.
// One request is processed at a time: it passes the evaluation, multiply and divider
// start states, then the bit-serial divider (one quotient bit per cycle over the
// 26-bit angle product), then the result load, which waits while an earlier result
// is still unaccepted. The next request is accepted as soon as the result is
// registered, even while it waits for out_ready. Configuration writes take effect at
// once and are meant for idle periods only.
module motorized_fader_position_control_unit (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [mfpc_pkg::VAL_W-1:0]     target_value,
    input  logic [mfpc_pkg::VAL_W-1:0]     adc_reading,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mfpc_pkg::VAL_W-1:0]     position_value,
    output logic signed [mfpc_pkg::ANG_W-1:0] angle,
    output logic                           moving,
    output logic [1:0]                     motor_command,
    output logic [mfpc_pkg::SPD_W-1:0]     motor_speed,

    input  logic                           cfg_we,
    input  logic [mfpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mfpc_pkg::CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIVST,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [mfpc_pkg::VAL_W-1:0] absdiff(
        input logic [mfpc_pkg::VAL_W-1:0] a,
        input logic [mfpc_pkg::VAL_W-1:0] b
    );
        absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // configuration
    logic [mfpc_pkg::VAL_W-1:0] value_max_reg;
    logic [mfpc_pkg::ANG_W-1:0] angle_min_reg;
    logic [mfpc_pkg::ANG_W-1:0] angle_max_reg;
    logic [mfpc_pkg::VAL_W-1:0] noise_thr_reg;
    logic [mfpc_pkg::VAL_W-1:0] pos_thr_reg;
    logic                       motor_pres_reg;

    // control and block state
    state_t                     state_reg;
    logic                       op_reg;
    logic [mfpc_pkg::VAL_W-1:0] cur_reg;
    logic [mfpc_pkg::VAL_W-1:0] target_reg;
    logic                       moving_reg;

    // result register
    logic                       out_valid_reg;
    logic [mfpc_pkg::VAL_W-1:0] out_pos_reg;
    logic [mfpc_pkg::ANG_W-1:0] out_angle_reg;
    logic                       out_moving_reg;
    mfpc_pkg::cmd_t             out_cmd_reg;
    logic [mfpc_pkg::SPD_W-1:0] out_speed_reg;

    // datapath
    mfpc_pkg::cmd_t               cmd_reg;
    logic [mfpc_pkg::VAL_W-1:0]   mag_reg;
    logic signed [26:0]           prod_a_reg;
    logic [mfpc_pkg::PROD_S_W-1:0] prod_s_reg;

    logic                         in_acc;
    logic                         out_free;
    logic [mfpc_pkg::VAL_W-1:0]   new_cur;
    logic [mfpc_pkg::VAL_W-1:0]   mag;
    logic                         active;
    mfpc_pkg::cmd_t               cmd_next;
    logic signed [16:0]           span;
    logic [26:0]                  prod_a_abs;
    logic                         div_start;
    logic                         busy_a;
    logic                         busy_s;
    logic [mfpc_pkg::PROD_A_W-1:0] quo_a;
    logic [mfpc_pkg::PROD_S_W-1:0] quo_s;
    logic [mfpc_pkg::ANG_W-1:0]   ang_q;
    logic [mfpc_pkg::ANG_W-1:0]   angle_next;
    logic [mfpc_pkg::SPD_W-1:0]   speed_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign div_start = (state_reg == ST_DIVST);

    always_comb
    begin
        new_cur = (absdiff(adc_reading, cur_reg) >= noise_thr_reg) ? adc_reading : cur_reg;
        mag     = absdiff(target_reg, cur_reg);
        active  = (op_reg == mfpc_pkg::OP_TICK) && motor_pres_reg && moving_reg;
        if (!active)
            cmd_next = mfpc_pkg::CMD_NONE;
        else if (mag <= pos_thr_reg)
            cmd_next = mfpc_pkg::CMD_STOP;
        else if (target_reg >= cur_reg)
            cmd_next = mfpc_pkg::CMD_BACK;
        else
            cmd_next = mfpc_pkg::CMD_FWD;

        span       = $signed({angle_max_reg[mfpc_pkg::ANG_W-1], angle_max_reg})
                   - $signed({angle_min_reg[mfpc_pkg::ANG_W-1], angle_min_reg});
        prod_a_abs = prod_a_reg[26] ? 27'(-prod_a_reg) : 27'(prod_a_reg);

        // only the low bits of the quotient reach the wrapped angle
        ang_q = prod_a_reg[26] ? (mfpc_pkg::ANG_W'(0) - quo_a[mfpc_pkg::ANG_W-1:0])
                               : quo_a[mfpc_pkg::ANG_W-1:0];
        if (value_max_reg == '0)
            angle_next = angle_min_reg;
        else
            angle_next = ang_q + angle_min_reg;

        if (cmd_reg == mfpc_pkg::CMD_FWD || cmd_reg == mfpc_pkg::CMD_BACK)
        begin
            if (value_max_reg == '0 || quo_s > mfpc_pkg::PROD_S_W'(mfpc_pkg::SPD_SPAN))
                speed_next = mfpc_pkg::SPD_HIGH;
            else
                speed_next = mfpc_pkg::SPD_LOW + quo_s[mfpc_pkg::SPD_W-1:0];
        end
        else
            speed_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_max_reg  <= 10'd1023;
            angle_min_reg  <= 16'd0;
            angle_max_reg  <= 16'd270;
            noise_thr_reg  <= 10'd4;
            pos_thr_reg    <= 10'd8;
            motor_pres_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfpc_pkg::CFG_VALUE_MAX:    value_max_reg  <= cfg_data[mfpc_pkg::VAL_W-1:0];
                mfpc_pkg::CFG_ANGLE_MIN:    angle_min_reg  <= cfg_data;
                mfpc_pkg::CFG_ANGLE_MAX:    angle_max_reg  <= cfg_data;
                mfpc_pkg::CFG_NOISE_THR:    noise_thr_reg  <= cfg_data[mfpc_pkg::VAL_W-1:0];
                mfpc_pkg::CFG_POSITION_THR: pos_thr_reg    <= cfg_data[mfpc_pkg::VAL_W-1:0];
                mfpc_pkg::CFG_MOTOR_PRES:   motor_pres_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= mfpc_pkg::OP_SET;
            cur_reg        <= '0;
            target_reg     <= '0;
            moving_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_angle_reg  <= '0;
            out_moving_reg <= 1'b0;
            out_cmd_reg    <= mfpc_pkg::CMD_NONE;
            out_speed_reg  <= '0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        op_reg <= operation;
                        if (operation == mfpc_pkg::OP_TICK)
                            cur_reg <= new_cur;
                        else if (!motor_pres_reg
                                 || absdiff(target_value, cur_reg) <= pos_thr_reg)
                            moving_reg <= 1'b0;
                        else
                        begin
                            target_reg <= target_value;
                            moving_reg <= 1'b1;
                        end
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (cmd_next == mfpc_pkg::CMD_STOP)
                        moving_reg <= 1'b0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:   state_reg <= ST_DIVST;
                ST_DIVST: state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (!busy_a && !busy_s)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_pos_reg    <= cur_reg;
                        out_angle_reg  <= angle_next;
                        out_moving_reg <= moving_reg;
                        out_cmd_reg    <= cmd_reg;
                        out_speed_reg  <= speed_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            cmd_reg <= cmd_next;
            mag_reg <= mag;
        end
        if (state_reg == ST_MUL)
        begin
            prod_a_reg <= 27'($signed({1'b0, cur_reg})) * 27'(span);
            prod_s_reg <= mfpc_pkg::PROD_S_W'(mag_reg)
                        * mfpc_pkg::PROD_S_W'(mfpc_pkg::SPD_SPAN);
        end
    end

    mfpc_sdiv #(
        .NUM_W(mfpc_pkg::PROD_A_W)
    ) u_div_angle (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_a_abs[mfpc_pkg::PROD_A_W-1:0]),
        .divisor  (value_max_reg),
        .busy     (busy_a),
        .quotient (quo_a)
    );

    mfpc_sdiv #(
        .NUM_W(mfpc_pkg::PROD_S_W)
    ) u_div_speed (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_s_reg),
        .divisor  (value_max_reg),
        .busy     (busy_s),
        .quotient (quo_s)
    );

    assign out_valid      = out_valid_reg;
    assign position_value = out_pos_reg;
    assign angle          = $signed(out_angle_reg);
    assign moving         = out_moving_reg;
    assign motor_command  = out_cmd_reg;
    assign motor_speed    = out_speed_reg;

    // dividers never run while a new request can be taken
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !busy_a && !busy_s)
        else $error("divider busy while idle");

    // a stop command always ends the move in the same result
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_cmd_reg == mfpc_pkg::CMD_STOP |-> !out_moving_reg)
        else $error("stop result still reports moving");

    // drive speed is in range while driving and zero otherwise
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_cmd_reg == mfpc_pkg::CMD_FWD || out_cmd_reg == mfpc_pkg::CMD_BACK)
                ? (out_speed_reg >= mfpc_pkg::SPD_LOW && out_speed_reg <= mfpc_pkg::SPD_HIGH)
                : (out_speed_reg == '0)))
        else $error("motor speed out of range");

endmodule
